### design/dhte_pkg.sv
package dhte_pkg;

  // Operation codes carried in the input tuser.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Result codes carried in the output tuser.
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

  // Slot marks as held in the mark memory.
  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_LIVE    = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned TOTAL_W = 10;
  localparam int unsigned LIMIT_W = 10;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned HASH_W  = 64;
  localparam int unsigned DIGITS  = HASH_W / DIGIT_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd765;

  // Controller states.
  typedef enum logic [2:0] {
    CS_INIT,
    CS_IDLE,
    CS_HASH,
    CS_SEEK,
    CS_PROBE,
    CS_CLR,
    CS_EMIT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    hash_step;
    logic    probe_start;
    logic    probe_next;
    logic    take_free;
    logic    wr_update;
    logic    wr_insert;
    logic    wr_delete;
    logic    sweep_start;
    logic    sweep_step;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clear;
    logic    emit;
    status_e result;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hash_last;
    logic probe_last;
    logic sweep_last;
    logic slot_live;
    logic slot_empty;
    logic key_hit;
    logic free_any;
    logic at_limit;
    logic out_free;
  } dp_status_t;

endpackage

### design/dhte_ram.sv
module dhte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/dhte_datapath.sv
module dhte_datapath import dhte_pkg::*; #(
  parameter int unsigned CAPACITY = 1021
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  logic [KEY_W-1:0]     key_i,
  input  logic [VALUE_W-1:0]   value_i,
  input  logic [LIMIT_W-1:0]   max_entries_i,
  input  logic                 out_ready_i,
  output dp_status_t           sts_o,
  output logic                 out_valid_o,
  output status_e              out_status_o,
  output logic [TOTAL_W-1:0]   out_total_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned RW = IW + DIGIT_W;
  localparam int unsigned XW = CW + TOTAL_W;
  localparam logic [RW-1:0] MOD_A = RW'(CAPACITY);
  localparam logic [RW-1:0] MOD_B = RW'(CAPACITY - 2);
  localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
  localparam logic [$clog2(DIGITS)-1:0] LAST_DIGIT = $clog2(DIGITS)'(DIGITS - 1);

  // Reduce a value below 16*m to below m by four conditional subtractions.
  function automatic logic [RW-1:0] reduce(input logic [RW-1:0] t, input logic [RW-1:0] m);
    logic [RW-1:0] r;
    r = t;
    for (int k = DIGIT_W - 1; k >= 0; k--) begin
      if (r >= (m << k)) begin
        r = r - (m << k);
      end
    end
    return r;
  endfunction

  logic [HASH_W-1:0]          h_q;
  logic [RW-1:0]              rem_a_q, rem_b_q;
  logic [$clog2(DIGITS)-1:0]  dg_q;
  logic [KEY_W-1:0]           key_q;
  logic [VALUE_W-1:0]         value_q;
  logic [IW-1:0]              idx_q, step_q, n_q, free_q, sw_q;
  logic                       have_free_q;
  logic [CW-1:0]              count_q;
  logic                       out_valid_q;
  status_e                    out_status_q;
  logic [TOTAL_W-1:0]         out_total_q;

  logic [RW-1:0]  rem_a_d, rem_b_d;
  logic [IW-1:0]  home, next_idx, ins_addr, raddr;
  logic [IW:0]    sum;
  logic [1:0]     rd_mark;
  logic [KEY_W-1:0] rd_key;
  logic [VALUE_W-1:0] rd_value_unused;
  logic           mark_we, value_we;
  logic [IW-1:0]  mark_waddr, value_waddr;
  logic [1:0]     mark_wdata;
  logic [XW-1:0]  count_x;

  // One nibble of the widened key per step, reduced by both moduli.
  assign rem_a_d = reduce({rem_a_q[IW-1:0], h_q[HASH_W-1 -: DIGIT_W]}, MOD_A);
  assign rem_b_d = reduce({rem_b_q[IW-1:0], h_q[HASH_W-1 -: DIGIT_W]}, MOD_B);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dg_q <= '0;
    end else if (cmd_i.load) begin
      dg_q <= '0;
    end else if (cmd_i.hash_step) begin
      dg_q <= dg_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      h_q     <= {{(HASH_W - KEY_W){key_i[KEY_W-1]}}, key_i};
      key_q   <= key_i;
      value_q <= value_i;
      rem_a_q <= '0;
      rem_b_q <= '0;
    end else if (cmd_i.hash_step) begin
      h_q     <= h_q << DIGIT_W;
      rem_a_q <= rem_a_d;
      rem_b_q <= rem_b_d;
    end
  end

  // Probe address walk: next = (idx + step) mod CAPACITY.
  assign home     = rem_a_q[IW-1:0];
  assign sum      = {1'b0, idx_q} + {1'b0, step_q};
  assign next_idx = (sum >= (IW+1)'(CAPACITY)) ? IW'(sum - (IW+1)'(CAPACITY)) : sum[IW-1:0];
  assign raddr    = cmd_i.probe_start ? home : next_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_start) begin
      idx_q  <= home;
      step_q <= rem_b_q[IW-1:0] + 1'b1;
      n_q    <= '0;
    end else if (cmd_i.probe_next) begin
      idx_q <= next_idx;
      n_q   <= n_q + 1'b1;
    end
    if (cmd_i.take_free && !have_free_q) begin
      free_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_free_q <= 1'b0;
    end else if (cmd_i.probe_start) begin
      have_free_q <= 1'b0;
    end else if (cmd_i.take_free) begin
      have_free_q <= 1'b1;
    end
  end

  // Sweep pointer for the mark memory clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= '0;
    end else if (cmd_i.sweep_start) begin
      sw_q <= '0;
    end else if (cmd_i.sweep_step) begin
      sw_q <= (sw_q == LAST_SLOT) ? '0 : sw_q + 1'b1;
    end
  end

  // Live entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.cnt_clear) begin
      count_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      count_q <= count_q + 1'b1;
    end else if (cmd_i.cnt_dec && (count_q != '0)) begin
      count_q <= count_q - 1'b1;
    end
  end

  // Memory write steering.
  assign ins_addr    = have_free_q ? free_q : idx_q;
  assign mark_we     = cmd_i.sweep_step | cmd_i.wr_insert | cmd_i.wr_delete;
  assign mark_waddr  = cmd_i.sweep_step ? sw_q : (cmd_i.wr_insert ? ins_addr : idx_q);
  assign mark_wdata  = cmd_i.sweep_step ? MARK_EMPTY :
                       (cmd_i.wr_insert ? MARK_LIVE : MARK_DELETED);
  assign value_we    = cmd_i.wr_insert | cmd_i.wr_update;
  assign value_waddr = cmd_i.wr_insert ? ins_addr : idx_q;

  dhte_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .raddr_i (raddr),
    .rdata_o (rd_mark)
  );

  dhte_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_insert),
    .waddr_i (ins_addr),
    .wdata_i (key_q),
    .raddr_i (raddr),
    .rdata_o (rd_key)
  );

  // Values are only written; lookups never return them.
  dhte_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (value_we),
    .waddr_i (value_waddr),
    .wdata_i (value_q),
    .raddr_i (raddr),
    .rdata_o (rd_value_unused)
  );

  // Result register.
  assign count_x = XW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.result;
      out_total_q  <= count_x[TOTAL_W-1:0];
    end
  end

  assign sts_o.hash_last  = (dg_q == LAST_DIGIT);
  assign sts_o.probe_last = (n_q == LAST_SLOT);
  assign sts_o.sweep_last = (sw_q == LAST_SLOT);
  assign sts_o.slot_live  = (rd_mark == MARK_LIVE);
  assign sts_o.slot_empty = (rd_mark == MARK_EMPTY);
  assign sts_o.key_hit    = (rd_key == key_q);
  assign sts_o.free_any   = have_free_q | (rd_mark != MARK_LIVE);
  assign sts_o.at_limit   = (count_x >= XW'(max_entries_i));
  assign sts_o.out_free   = !out_valid_q | out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_total_o  = out_total_q;

endmodule

### design/dhte_ctrl.sv
module dhte_ctrl import dhte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  op_e        in_op_i,
  input  dp_status_t sts_i,
  output logic       in_ready_o,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  op_e         op_q, op_d;
  status_e     res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_INIT;
      op_q    <= OP_NONE;
      res_q   <= ST_NOT_FOUND;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      res_q   <= res_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    res_d      = res_q;
    cmd_o      = '0;
    cmd_o.result = res_q;
    in_ready_o = 1'b0;
    case (state_q)
      CS_INIT: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = CS_IDLE;
        end
      end
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = in_op_i;
          case (in_op_i)
            OP_INSERT, OP_REMOVE: state_d = CS_HASH;
            OP_CLEAR: begin
              cmd_o.sweep_start = 1'b1;
              cmd_o.cnt_clear   = 1'b1;
              state_d           = CS_CLR;
            end
            default: begin
              res_d   = ST_NOT_FOUND;
              state_d = CS_EMIT;
            end
          endcase
        end
      end
      CS_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.hash_last) begin
          state_d = CS_SEEK;
        end
      end
      CS_SEEK: begin
        cmd_o.probe_start = 1'b1;
        state_d           = CS_PROBE;
      end
      CS_PROBE: begin
        if (op_q == OP_INSERT) begin
          if (sts_i.slot_live && sts_i.key_hit) begin
            cmd_o.wr_update = 1'b1;
            res_d           = ST_UPDATED;
            state_d         = CS_EMIT;
          end else begin
            cmd_o.take_free = !sts_i.slot_live;
            if (sts_i.slot_empty || sts_i.probe_last) begin
              state_d = CS_EMIT;
              if (sts_i.at_limit || !sts_i.free_any) begin
                res_d = ST_FULL;
              end else begin
                cmd_o.wr_insert = 1'b1;
                cmd_o.cnt_inc   = 1'b1;
                res_d           = ST_INSERTED;
              end
            end else begin
              cmd_o.probe_next = 1'b1;
            end
          end
        end else begin
          if (sts_i.slot_empty) begin
            res_d   = ST_NOT_FOUND;
            state_d = CS_EMIT;
          end else if (sts_i.slot_live && sts_i.key_hit) begin
            cmd_o.wr_delete = 1'b1;
            cmd_o.cnt_dec   = 1'b1;
            res_d           = ST_REMOVED;
            state_d         = CS_EMIT;
          end else if (sts_i.probe_last) begin
            res_d   = ST_NOT_FOUND;
            state_d = CS_EMIT;
          end else begin
            cmd_o.probe_next = 1'b1;
          end
        end
      end
      CS_CLR: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          res_d   = ST_CLEARED;
          state_d = CS_EMIT;
        end
      end
      CS_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

endmodule

### design/double_hash_table_engine_top.sv
// Open-addressing hash table with double hashing, signed 32-bit keys and 64-bit
// values. One operation is worked at a time: an insert or remove is accepted,
// its key is hashed one nibble per cycle through two modulo units, the walk is
// started, the mark and key memories are probed slot after slot, and the result
// is posted. A clear sweeps the mark memory one slot per cycle. After reset the
// same sweep runs with s_axis_tready low; configuration writes are taken
// meanwhile. The result beat sits in an output register, so a new operation is
// accepted while it waits.
module double_hash_table_engine_top import dhte_pkg::*; #(
  parameter int unsigned CAPACITY = 1021
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // [31:0] key, [95:32] value
  input  logic [1:0]   s_axis_tuser,   // [1:0] op
  // Output stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata,   // [9:0] entry_total, [15:10] zero
  output logic [2:0]   m_axis_tuser,   // [2:0] status
  // Register port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  dp_cmd_t             cmd;
  dp_status_t          sts;
  logic [LIMIT_W-1:0]  max_entries_q;
  status_e             out_status;
  logic [TOTAL_W-1:0]  out_total;

  // Load limit register at byte address 0.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      max_entries_q <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = paddr[2] ? '0 : 32'(max_entries_q);

  dhte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (op_e'(s_axis_tuser)),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  dhte_datapath #(.CAPACITY(CAPACITY)) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .key_i         (s_axis_tdata[31:0]),
    .value_i       (s_axis_tdata[95:32]),
    .max_entries_i (max_entries_q),
    .out_ready_i   (m_axis_tready),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_status_o  (out_status),
    .out_total_o   (out_total)
  );

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {6'd0, out_total};

  // Only known result codes leave the block.
  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= ST_CLEARED))
    else $error("unknown status code on output");

  // A clear always reports an empty table.
  a_clear_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_CLEARED) |-> (m_axis_tdata[9:0] == 10'd0))
    else $error("clear reported live entries");

  // One operation at a time: an accepted beat drops ready for the next cycle.
  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second operation accepted while busy");

endmodule

### dv/tb_double_hash_table_engine_top.sv
module tb_double_hash_table_engine_top;
  import dhte_pkg::*;

  localparam int unsigned SLOTS = 1021;
  localparam int unsigned KEY_POOL = 48;
  localparam int unsigned PHASE_ITEMS = 275;

  // Expected reply of one operation.
  typedef struct {
    status_e          status;
    logic [TOTAL_W-1:0] total;
  } reply_t;

  // One row of the directed stimulus; typed rows carry their own answer.
  typedef struct {
    op_e                op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    status_e            status;
    logic [TOTAL_W-1:0] total;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Shadow copy of the table.
  logic [1:0]         shadow_mark [SLOTS];
  logic [KEY_W-1:0]   shadow_key [SLOTS];
  logic [VALUE_W-1:0] shadow_value [SLOTS];
  int unsigned        shadow_live;
  logic [LIMIT_W-1:0] shadow_limit;

  reply_t pending_replies[$];
  logic [KEY_W-1:0] key_pool [KEY_POOL];
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int hold_left;
  int errors;
  int ops_sent;
  int replies_seen;
  int status_seen [6];

  double_hash_table_engine_top #(.CAPACITY(SLOTS)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one operation to the shadow table and return the reply it earns.
  function automatic reply_t table_apply(op_e op, logic [KEY_W-1:0] k,
                                         logic [VALUE_W-1:0] v);
    reply_t r;
    longint unsigned h;
    int unsigned idx;
    int unsigned stride;
    int unsigned free_idx;
    bit have_free;
    h = {{32{k[31]}}, k};
    idx = 32'(h % SLOTS);
    stride = 32'(1 + h % (SLOTS - 2));
    have_free = 0;
    free_idx = 0;
    r.status = ST_NOT_FOUND;
    if (op == OP_INSERT) begin
      r.status = ST_FULL;
      for (int n = 0; n < SLOTS; n++) begin
        if (shadow_mark[idx] == MARK_LIVE) begin
          if (shadow_key[idx] == k) begin
            shadow_value[idx] = v;
            r.status = ST_UPDATED;
            break;
          end
        end else begin
          if (!have_free) begin
            have_free = 1;
            free_idx = idx;
          end
          if (shadow_mark[idx] == MARK_EMPTY) break;
        end
        idx = (idx + stride) % SLOTS;
      end
      if (r.status != ST_UPDATED && shadow_live < shadow_limit && have_free) begin
        shadow_mark[free_idx] = MARK_LIVE;
        shadow_key[free_idx] = k;
        shadow_value[free_idx] = v;
        shadow_live++;
        r.status = ST_INSERTED;
      end
    end else if (op == OP_REMOVE) begin
      // Removal leaves a tombstone so later chains still pass through.
      for (int n = 0; n < SLOTS; n++) begin
        if (shadow_mark[idx] == MARK_EMPTY) break;
        if (shadow_mark[idx] == MARK_LIVE && shadow_key[idx] == k) begin
          shadow_mark[idx] = MARK_DELETED;
          if (shadow_live > 0) shadow_live--;
          r.status = ST_REMOVED;
          break;
        end
        idx = (idx + stride) % SLOTS;
      end
    end else if (op == OP_CLEAR) begin
      foreach (shadow_mark[i]) shadow_mark[i] = MARK_EMPTY;
      shadow_live = 0;
      r.status = ST_CLEARED;
    end
    r.total = shadow_live[TOTAL_W-1:0];
    return r;
  endfunction

  // Offer one beat and wait for it to be taken; the gap comes first.
  task automatic send_op(op_e op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v,
                         bit typed, status_e st, logic [TOTAL_W-1:0] tot);
    reply_t r;
    bit taken;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {v, k};
    forever begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
      if (taken) break;
    end
    r = table_apply(op, k, v);
    if (typed) begin
      r.status = st;
      r.total = tot;
    end
    pending_replies.push_back(r);
    ops_sent++;
  endtask

  // Register write followed by a read back of the same register.
  task automatic write_limit(logic [LIMIT_W-1:0] lim);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= 32'(lim);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata[LIMIT_W-1:0] !== lim) begin
      $display("%0t: max_entries read back expected %0d actual %0d", $time, lim,
               prdata[LIMIT_W-1:0]);
      errors++;
    end
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
    shadow_limit = lim;
  endtask

  task automatic wait_drained();
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 75) return key_pool[$urandom_range(KEY_POOL - 1)];
    return $urandom;
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each reply beat with the oldest expectation.
  always @(negedge clk_i) begin
    reply_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      replies_seen++;
      if (m_axis_tuser < 6) status_seen[m_axis_tuser]++;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply status %0d total %0d", $time, m_axis_tuser,
                 m_axis_tdata[9:0]);
        errors++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (m_axis_tuser !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[9:0] !== exp_r.total) begin
          $display("%0t: entry_total expected %0d actual %0d", $time, exp_r.total,
                   m_axis_tdata[9:0]);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    row_t rows[$];
    logic [LIMIT_W-1:0] phase_limit [6];
    int r;
    op_e op;
    errors = 0;
    ops_sent = 0;
    replies_seen = 0;
    hold_req = 0;
    hold_left = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (shadow_mark[i]) shadow_mark[i] = MARK_EMPTY;
    shadow_live = 0;
    shadow_limit = LIMIT_RESET;
    send_idle_pct = 13;
    recv_idle_pct = 86;
    phase_limit = '{10'd1, 10'd0, 10'd12, 10'd1020, 10'd40, 10'd765};

    // Directed rows: empty table, extremes of the key, a shared home slot,
    // a tombstone in the chain, clear, and the unused opcode.
    rows = '{
      '{OP_NONE,   32'h0000_0000, '1, 1, ST_NOT_FOUND, 10'd0},
      '{OP_REMOVE, 32'h0000_0005, '0, 1, ST_NOT_FOUND, 10'd0},
      '{OP_INSERT, 32'h7FFF_FFFF, '1, 1, ST_INSERTED, 10'd1},
      '{OP_INSERT, 32'h8000_0000, '0, 1, ST_INSERTED, 10'd2},
      '{OP_INSERT, 32'h8000_0000, 64'h5555_AAAA_5555_AAAA, 1, ST_UPDATED, 10'd2},
      '{OP_INSERT, 32'd0,    64'h1, 1, ST_INSERTED, 10'd3},
      '{OP_INSERT, 32'd1021, 64'h2, 1, ST_INSERTED, 10'd4},
      '{OP_INSERT, 32'd2042, 64'h3, 1, ST_INSERTED, 10'd5},
      '{OP_REMOVE, 32'd1021, '0, 1, ST_REMOVED, 10'd4},
      '{OP_INSERT, 32'd2042, 64'h4, 1, ST_UPDATED, 10'd4},
      '{OP_INSERT, 32'd1021, 64'h5, 0, ST_INSERTED, 10'd0},
      '{OP_INSERT, 32'hFFFF_FFFF, '1, 0, ST_INSERTED, 10'd0},
      '{OP_INSERT, 32'hFFFF_FC03, 64'h6, 0, ST_INSERTED, 10'd0},
      '{OP_REMOVE, 32'hFFFF_FFFF, '0, 0, ST_REMOVED, 10'd0},
      '{OP_REMOVE, 32'hFFFF_FFFF, '0, 0, ST_NOT_FOUND, 10'd0},
      '{OP_REMOVE, 32'h7FFF_FFFF, '0, 0, ST_REMOVED, 10'd0},
      '{OP_CLEAR,  32'h1234_5678, '1, 1, ST_CLEARED, 10'd0},
      '{OP_REMOVE, 32'd0,    '0, 1, ST_NOT_FOUND, 10'd0},
      '{OP_INSERT, 32'd2042, '1, 1, ST_INSERTED, 10'd1},
      '{OP_NONE,   32'hFFFF_FFFF, '1, 1, ST_NOT_FOUND, 10'd1}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i])
      send_op(rows[i].op, rows[i].key, rows[i].value, rows[i].typed,
              rows[i].status, rows[i].total);

    // Random phases, each under its own load limit, with one of three idling patterns.
    for (int ph = 0; ph < 6; ph++) begin
      s_axis_tvalid <= 1'b0;
      wait_drained();
      write_limit(phase_limit[ph]);
      if (ph < 2) begin
        send_idle_pct = 13; recv_idle_pct = 86;
      end else if (ph < 4) begin
        send_idle_pct = 86; recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      // Keys that crowd a few home slots, plus negatives near the wrap.
      foreach (key_pool[i]) begin
        case (i % 3)
          0: key_pool[i] = $urandom_range(200);
          1: key_pool[i] = 1021 * $urandom_range(40) + $urandom_range(3);
          default: key_pool[i] = -$urandom_range(3000, 1);
        endcase
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == 20) hold_req = 1;
        r = $urandom_range(199);
        if (r < 3) op = OP_CLEAR;
        else if (r < 9) op = OP_NONE;
        else if (r < 120) op = OP_INSERT;
        else op = OP_REMOVE;
        send_op(op, pick_key(), {$urandom, $urandom}, 0, ST_NOT_FOUND, '0);
      end
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();

    $display("Sent %0d operations, checked %0d replies under six load limits.",
             ops_sent, replies_seen);
    $display("Replies: %0d inserted, %0d updated, %0d removed, %0d not found,",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("         %0d full, %0d cleared.", status_seen[4], status_seen[5]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/dhte_pkg.sv
design/dhte_ram.sv
design/dhte_datapath.sv
design/dhte_ctrl.sv
design/double_hash_table_engine_top.sv
dv/tb_double_hash_table_engine_top.sv
